/* hw/rtl/ccq_pkg.sv */
// shared types, constants and helper functions of the console cell color quantizer
`timescale 1ns / 1ps

package ccq_pkg;

    // palette geometry
    localparam int PAL_ENTRIES       = 16;
    localparam int PAIR_COUNT        = 8;
    localparam int PAIR_W            = 48;
    localparam int RGB_W             = 24;
    localparam int CFG_ADDR_W        = 3;
    localparam int IDX_W             = $clog2(PAL_ENTRIES);

    // searched entries of each side
    localparam int BACK_PALETTE_SIZE = 8;
    localparam int FORE_PALETTE_SIZE = 16;

    // distance of one color pair, max 3 * 255
    localparam int DIST_W = 10;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // field widths
    localparam int CHAR_IN_W  = 21;
    localparam int CHAR_OUT_W = 7;
    localparam int COLOR_W    = 32;
    localparam int INDEX_W    = 8;

    // stream widths
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    // character codes
    localparam logic [CHAR_IN_W-1:0]  CHAR_FIRST_KEEP = 21'd2;
    localparam logic [CHAR_IN_W-1:0]  CHAR_MIDDOT     = 21'd183;
    localparam logic [CHAR_IN_W-1:0]  CHAR_PRINT_LO   = 21'd32;
    localparam logic [CHAR_IN_W-1:0]  CHAR_ASCII_END  = 21'd128;
    localparam logic [CHAR_OUT_W-1:0] CHAR_SPACE      = 7'd32;
    localparam logic [CHAR_OUT_W-1:0] CHAR_DOT        = 7'd46;
    localparam logic [CHAR_OUT_W-1:0] CHAR_DOLLAR     = 7'd36;
    localparam logic [CHAR_OUT_W-1:0] CHAR_QMARK      = 7'd63;

    // index codes
    localparam logic [INDEX_W-1:0] BLACK_INDEX        = 8'd0;
    localparam logic [INDEX_W-1:0] FORE_DEFAULT_INDEX = 8'd7;

    // xterm cube
    localparam logic [INDEX_W-1:0] CUBE_BASE  = 8'd16;
    localparam logic [8:0]         CUBE_ROUND = 9'd25;
    localparam int                 CUBE_STEP  = 51;
    localparam int                 CUBE_LEVELS = 5;

    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [PAL_ENTRIES-1:0][DIST_W-1:0] t_dist_arr;
    typedef logic [PAL_ENTRIES-1:0][RGB_W-1:0] t_palette;

    // after distance stage
    typedef struct packed {
        logic [CHAR_OUT_W-1:0] out_char;
        logic                  back_def;
        logic                  fore_def;
        logic [INDEX_W-1:0]    back_top;
        logic [INDEX_W-1:0]    fore_top;
        logic                  back_black;
        logic                  fore_black;
        logic                  same_color;
        logic [INDEX_W-1:0]    back_cube;
        logic [INDEX_W-1:0]    fore_cube;
        t_dist_arr             back_dist;
        t_dist_arr             fore_dist;
    } t_s1;

    // after background select
    typedef struct packed {
        logic [CHAR_OUT_W-1:0] out_char;
        logic                  back_def;
        logic                  fore_def;
        logic [INDEX_W-1:0]    back_index;
        logic [INDEX_W-1:0]    fore_top;
        logic                  fore_black;
        logic                  same_color;
        logic [INDEX_W-1:0]    back_cube;
        logic [INDEX_W-1:0]    fore_cube;
        t_dist_arr             fore_dist;
    } t_s2;

    // finished result
    typedef struct packed {
        logic [CHAR_OUT_W-1:0] out_char;
        logic [INDEX_W-1:0]    back_index;
        logic                  back_def;
        logic [INDEX_W-1:0]    fore_index;
        logic [INDEX_W-1:0]    back_cube;
        logic [INDEX_W-1:0]    fore_cube;
    } t_res;

    function automatic logic [7:0] byte_diff(logic [7:0] a, logic [7:0] b);
        byte_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // sum of absolute byte differences of two 0xRRGGBB colors
    function automatic t_dist rgb_distance(logic [RGB_W-1:0] a, logic [RGB_W-1:0] b);
        rgb_distance = {2'b00, byte_diff(a[7:0], b[7:0])}
                     + {2'b00, byte_diff(a[15:8], b[15:8])}
                     + {2'b00, byte_diff(a[23:16], b[23:16])};
    endfunction

    // lowest index of the least distance, pairwise tree
    function automatic logic [IDX_W-1:0] argmin(t_dist_arr d);
        t_dist_arr               dv;
        logic [IDX_W-1:0]        iv [PAL_ENTRIES];
        int                      step;
        int                      i;
        dv = d;
        for (i = 0; i < PAL_ENTRIES; i++) begin
            iv[i] = IDX_W'(i);
        end
        for (step = 1; step < PAL_ENTRIES; step = step * 2) begin
            for (i = 0; i + step < PAL_ENTRIES; i = i + 2 * step) begin
                if (dv[i+step] < dv[i]) begin
                    dv[i] = dv[i+step];
                    iv[i] = iv[i+step];
                end
            end
        end
        argmin = iv[0];
    endfunction

    // (byte + 25) / 51 as a threshold count
    function automatic logic [2:0] cube_level(logic [7:0] b);
        logic [8:0] v;
        logic [2:0] q;
        int         k;
        v = {1'b0, b} + CUBE_ROUND;
        q = '0;
        for (k = 1; k <= CUBE_LEVELS; k++) begin
            if (v >= 9'(k * CUBE_STEP)) begin
                q = q + 3'd1;
            end
        end
        cube_level = q;
    endfunction

    function automatic logic [INDEX_W-1:0] cube_index(logic [COLOR_W-1:0] c);
        logic [INDEX_W-1:0] r5;
        logic [INDEX_W-1:0] g5;
        logic [INDEX_W-1:0] b5;
        b5 = {5'b0, cube_level(c[7:0])};
        g5 = {5'b0, cube_level(c[15:8])};
        r5 = {5'b0, cube_level(c[23:16])};
        cube_index = CUBE_BASE + b5 + g5 * 8'd6 + r5 * 8'd36;
    endfunction

    function automatic logic [CHAR_OUT_W-1:0] sanitize_char(logic [CHAR_IN_W-1:0] ch);
        logic [CHAR_OUT_W-1:0] r;
        priority if (ch < CHAR_FIRST_KEEP) begin
            r = CHAR_SPACE;
        end else if (ch == CHAR_MIDDOT) begin
            r = CHAR_DOT;
        end else if (ch < CHAR_PRINT_LO) begin
            r = CHAR_DOLLAR;
        end else if (ch >= CHAR_ASCII_END) begin
            r = CHAR_QMARK;
        end else begin
            r = ch[CHAR_OUT_W-1:0];
        end
        sanitize_char = r;
    endfunction

endpackage

/* hw/rtl/ccq_dist_stage.sv */
// first stage: palette distances, character cleanup and cube indices
`timescale 1ns / 1ps

module ccq_dist_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [ccq_pkg::CHAR_IN_W-1:0]    i_cell_char,
    input  logic                             i_back_is_default,
    input  logic [ccq_pkg::COLOR_W-1:0]      i_back_color,
    input  logic                             i_fore_is_default,
    input  logic [ccq_pkg::COLOR_W-1:0]      i_fore_color,
    input  ccq_pkg::t_palette                i_palette,
    output logic                             o_valid,
    output ccq_pkg::t_s1                     o_stage
);

    logic         r_valid;
    ccq_pkg::t_s1 r_stage;
    ccq_pkg::t_s1 n_stage;

    always_comb begin
        n_stage.out_char   = ccq_pkg::sanitize_char(i_cell_char);
        n_stage.back_def   = i_back_is_default;
        n_stage.fore_def   = i_fore_is_default;
        n_stage.back_top   = i_back_color[31:24];
        n_stage.fore_top   = i_fore_color[31:24];
        n_stage.back_black = (i_back_color == '0);
        n_stage.fore_black = (i_fore_color == '0);
        n_stage.same_color = (i_back_color == i_fore_color);
        n_stage.back_cube  = ccq_pkg::cube_index(i_back_color);
        n_stage.fore_cube  = ccq_pkg::cube_index(i_fore_color);
        // entries past a side's size never win
        for (int e = 0; e < ccq_pkg::PAL_ENTRIES; e++) begin
            n_stage.back_dist[e] = (e < ccq_pkg::BACK_PALETTE_SIZE)
                ? ccq_pkg::rgb_distance(i_back_color[23:0], i_palette[e])
                : ccq_pkg::DIST_MAX;
            n_stage.fore_dist[e] = (e < ccq_pkg::FORE_PALETTE_SIZE)
                ? ccq_pkg::rgb_distance(i_fore_color[23:0], i_palette[e])
                : ccq_pkg::DIST_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

/* hw/rtl/ccq_back_stage.sv */
// second stage: background palette index
`timescale 1ns / 1ps

module ccq_back_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  ccq_pkg::t_s1 i_stage,
    output logic         o_valid,
    output ccq_pkg::t_s2 o_stage
);

    logic                          r_valid;
    ccq_pkg::t_s2                  r_stage;
    ccq_pkg::t_s2                  n_stage;
    logic [ccq_pkg::INDEX_W-1:0]   w_back_idx;

    always_comb begin
        priority if (i_stage.back_def) begin
            w_back_idx = ccq_pkg::BLACK_INDEX;
        end else if (i_stage.back_top != '0) begin
            w_back_idx = i_stage.back_top;
        end else if (i_stage.back_black) begin
            w_back_idx = ccq_pkg::BLACK_INDEX;
        end else begin
            w_back_idx = {{(ccq_pkg::INDEX_W - ccq_pkg::IDX_W){1'b0}},
                          ccq_pkg::argmin(i_stage.back_dist)};
        end

        n_stage.out_char   = i_stage.out_char;
        n_stage.back_def   = i_stage.back_def;
        n_stage.fore_def   = i_stage.fore_def;
        n_stage.back_index = w_back_idx;
        n_stage.fore_top   = i_stage.fore_top;
        n_stage.fore_black = i_stage.fore_black;
        n_stage.same_color = i_stage.same_color;
        n_stage.back_cube  = i_stage.back_cube;
        n_stage.fore_cube  = i_stage.fore_cube;
        n_stage.fore_dist  = i_stage.fore_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

/* hw/rtl/ccq_fore_stage.sv */
// third stage: foreground palette index; its register drives the output
`timescale 1ns / 1ps

module ccq_fore_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  ccq_pkg::t_s2  i_stage,
    output logic          o_valid,
    output ccq_pkg::t_res o_res
);

    logic                          r_valid;
    ccq_pkg::t_res                 r_res;
    ccq_pkg::t_res                 n_res;
    ccq_pkg::t_dist_arr            w_dist;
    logic                          w_has_forb;
    logic [ccq_pkg::INDEX_W-1:0]   w_fore_idx;

    always_comb begin
        w_has_forb = !i_stage.back_def;
        // a non-default background's entry is pushed out of the race
        for (int e = 0; e < ccq_pkg::PAL_ENTRIES; e++) begin
            w_dist[e] = (w_has_forb && i_stage.back_index == ccq_pkg::INDEX_W'(e))
                ? ccq_pkg::DIST_MAX : i_stage.fore_dist[e];
        end

        priority if (i_stage.fore_def) begin
            w_fore_idx = ccq_pkg::FORE_DEFAULT_INDEX;
        end else if (w_has_forb && i_stage.same_color) begin
            w_fore_idx = i_stage.back_index;
        end else if (i_stage.fore_top != '0) begin
            w_fore_idx = i_stage.fore_top;
        end else if (i_stage.fore_black
                     && !(w_has_forb && i_stage.back_index == ccq_pkg::BLACK_INDEX)) begin
            w_fore_idx = ccq_pkg::BLACK_INDEX;
        end else begin
            w_fore_idx = {{(ccq_pkg::INDEX_W - ccq_pkg::IDX_W){1'b0}},
                          ccq_pkg::argmin(w_dist)};
        end

        n_res.out_char   = i_stage.out_char;
        n_res.back_index = i_stage.back_index;
        n_res.back_def   = i_stage.back_def;
        n_res.fore_index = w_fore_idx;
        n_res.back_cube  = i_stage.back_cube;
        n_res.fore_cube  = i_stage.fore_cube;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* hw/rtl/console_cell_color_quantizer_unit.sv */
// top level of the console cell color quantizer: palette registers, pipeline and stream ports
`timescale 1ns / 1ps

// Console cell color quantizer. Each input item is one text cell: a character code and
// a background and a foreground color, each with a terminal-default flag. The block
// returns one item per cell: the character cleaned up to 7-bit ASCII, a palette index
// for each color, and the xterm-256 cube index of each color. A nonzero top byte is taken
// as the index itself and black maps to 0. Any other color goes to the nearest palette
// entry by sum of absolute RGB byte differences, ties to the lower index; the background
// searches entries 0 to 7, the foreground all 16. Unless the background is default, the
// foreground search skips the background's entry, a black foreground over background
// index 0 also searches, and equal colors on both sides share the background's index.
// A default foreground gives index 7. The palette is loaded through the write port, entry
// pair k at index k, and must only be written while no cell is in flight. Rate: one cell
// per clock while the output is not stalled. The pipeline is distances, background
// select, foreground select; the output handshake alone sets the pace, as a stall on the
// output freezes all three stages together.

module console_cell_color_quantizer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // palette write port
    input  logic                              i_cfg_we,
    input  logic [ccq_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ccq_pkg::PAIR_W-1:0]        i_cfg_wdata,
    // cell input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cell_char [20:0], back_color [52:21], fore_color [84:53], zero fill [87:85]
    input  logic [ccq_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // back_is_default [0], fore_is_default [1]
    input  logic [ccq_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_char [6:0], back_index [14:7], fore_index [22:15], back_cube [30:23],
    // fore_cube [38:31], zero fill [39]
    output logic [ccq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // back_default_out [0]
    output logic [ccq_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    // palette pairs, reset to black
    logic [ccq_pkg::PAIR_W-1:0] r_pal_pair [ccq_pkg::PAIR_COUNT];
    ccq_pkg::t_palette          w_palette;

    // pipeline
    logic           w_en;
    logic           w_s1_valid;
    ccq_pkg::t_s1   w_s1;
    logic           w_s2_valid;
    ccq_pkg::t_s2   w_s2;
    logic           w_s3_valid;
    ccq_pkg::t_res  w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < ccq_pkg::PAIR_COUNT; p++) begin
                r_pal_pair[p] <= '0;
            end
        end else if (i_cfg_we) begin
            r_pal_pair[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // even entry in the low half of a pair, odd entry in the high half
    always_comb begin
        for (int e = 0; e < ccq_pkg::PAL_ENTRIES; e++) begin
            w_palette[e] = (e % 2 == 0)
                ? r_pal_pair[e / 2][ccq_pkg::RGB_W-1:0]
                : r_pal_pair[e / 2][ccq_pkg::PAIR_W-1:ccq_pkg::RGB_W];
        end
    end

    // whole pipe advances when the output slot is free or being taken
    assign w_en          = !w_s3_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    ccq_dist_stage u_dist (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_valid           (s_axis_tvalid),
        .i_cell_char       (s_axis_tdata[20:0]),
        .i_back_is_default (s_axis_tuser[0]),
        .i_back_color      (s_axis_tdata[52:21]),
        .i_fore_is_default (s_axis_tuser[1]),
        .i_fore_color      (s_axis_tdata[84:53]),
        .i_palette         (w_palette),
        .o_valid           (w_s1_valid),
        .o_stage           (w_s1)
    );

    ccq_back_stage u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s1_valid),
        .i_stage (w_s1),
        .o_valid (w_s2_valid),
        .o_stage (w_s2)
    );

    ccq_fore_stage u_fore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s2_valid),
        .i_stage (w_s2),
        .o_valid (w_s3_valid),
        .o_res   (w_res)
    );

    assign m_axis_tvalid = w_s3_valid;
    assign m_axis_tdata  = {1'b0,
                            w_res.fore_cube,
                            w_res.back_cube,
                            w_res.fore_index,
                            w_res.back_index,
                            w_res.out_char};
    assign m_axis_tuser  = w_res.back_def;

endmodule
